// File: hw/rtl/sbc_pkg.sv
`default_nettype none
package sbc_pkg;

  localparam int CW        = 32;
  localparam int RW        = 31;
  localparam int NW        = 16;
  localparam int DW        = CW + 1;
  localparam int SQ_W      = 64;
  localparam int SQ_STAGES = 16;
  localparam int SQ_STEPS  = 2;
  localparam int DIV_BITS  = 15;
  localparam int REM_W     = RW + DIV_BITS + 1;

  localparam logic signed [NW-1:0] ONE_Q14  = 16'sd16384;
  localparam logic [DIV_BITS-1:0]  Q_MAX    = 15'd16384;
  localparam logic [RW-1:0]        PEN_MAX  = 31'h7fffffff;
  localparam logic                 REG_THR  = 1'b0;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic [RW-1:0]        radius;
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_min_z;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_max_y;
    logic signed [CW-1:0] box_max_z;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic                 center_inside;
    logic signed [NW-1:0] normal_x;
    logic signed [NW-1:0] normal_y;
    logic signed [NW-1:0] normal_z;
    logic [RW-1:0]        penetration;
  } out_t;

  typedef struct packed {
    out_t                 res;
    logic                 outside;
    logic [2:0]           neg;
    logic [2:0][RW-1:0]   mag;
    logic [RW-1:0]        r;
  } meta_t;

  typedef struct packed {
    logic [SQ_W-1:0] x;
    logic [SQ_W-1:0] res;
  } sq_t;

  function automatic sq_t sq_step(sq_t s, logic [5:0] sh);
    logic [SQ_W-1:0] b;
    logic [SQ_W-1:0] t;
    sq_t o;
    b = 64'd1 << sh;
    t = s.res + b;
    if (s.x >= t) begin
      o.x   = s.x - t;
      o.res = (s.res >> 1) + b;
    end else begin
      o.x   = s.x;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sbc_front.sv
`default_nettype none
module sbc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire sbc_pkg::in_t       in_data,
  input  wire logic [31:0]        thr,
  output logic                    out_valid,
  output logic [63:0]             out_dsq,
  output sbc_pkg::meta_t          out_meta
);
  import sbc_pkg::*;

  logic signed [CW-1:0] c [3];
  logic signed [CW-1:0] lo [3];
  logic signed [CW-1:0] hi [3];

  // clamp distances
  logic                 v1_r;
  logic signed [DW-1:0] dlo_r [3];
  logic signed [DW-1:0] dhi_r [3];
  logic [RW-1:0]        r1_r;

  // offsets and nearest face per axis
  logic                 v2_r;
  logic [RW-1:0]        mag2_r [3];
  logic [2:0]           neg2_r;
  logic                 far2_r;
  logic signed [DW-1:0] fd2_r [3];
  logic [2:0]           fsel2_r;
  logic [RW-1:0]        r2_r;

  // squares
  logic                 v3_r;
  logic [61:0]          sq3_r [3];
  logic [61:0]          rr3_r;
  logic [RW-1:0]        mag3_r [3];
  logic [2:0]           neg3_r;
  logic                 far3_r;
  logic signed [DW-1:0] bxy3_r;
  logic [1:0]           bax3_r;
  logic                 bhi3_r;
  logic signed [DW-1:0] fdz3_r;
  logic                 fselz3_r;
  logic [RW-1:0]        r3_r;

  // sum
  logic                 v4_r;
  logic [63:0]          dsq4_r;
  logic [61:0]          rr4_r;
  logic [RW-1:0]        mag4_r [3];
  logic [2:0]           neg4_r;
  logic                 far4_r;
  logic signed [DW-1:0] best4_r;
  logic [1:0]           bax4_r;
  logic                 bhi4_r;
  logic [RW-1:0]        r4_r;

  logic                 v5_r;
  logic [63:0]          dsq5_r;
  meta_t                meta5_r;

  logic signed [DW-1:0] dlo_nxt [3];
  logic signed [DW-1:0] dhi_nxt [3];
  logic [RW-1:0]        mag2_nxt [3];
  logic [2:0]           neg2_nxt;
  logic                 far2_nxt;
  logic signed [DW-1:0] fd2_nxt [3];
  logic [2:0]           fsel2_nxt;
  logic [61:0]          sq3_nxt [3];
  logic signed [DW-1:0] bxy3_nxt;
  logic [1:0]           bax3_nxt;
  logic                 bhi3_nxt;
  logic signed [DW-1:0] best4_nxt;
  logic [1:0]           bax4_nxt;
  logic                 bhi4_nxt;
  meta_t                meta5_nxt;
  logic [DW-1:0]        m;
  logic signed [34:0]   pw;
  logic                 nohit;
  logic                 outside;

  always_comb begin
    c[0]  = in_data.center_x;  c[1]  = in_data.center_y;  c[2]  = in_data.center_z;
    lo[0] = in_data.box_min_x; lo[1] = in_data.box_min_y; lo[2] = in_data.box_min_z;
    hi[0] = in_data.box_max_x; hi[1] = in_data.box_max_y; hi[2] = in_data.box_max_z;
    for (int a = 0; a < 3; a++) begin
      dlo_nxt[a] = $signed({c[a][CW-1], c[a]}) - $signed({lo[a][CW-1], lo[a]});
      dhi_nxt[a] = $signed({hi[a][CW-1], hi[a]}) - $signed({c[a][CW-1], c[a]});
    end
  end

  always_comb begin
    m        = '0;
    far2_nxt = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (dlo_r[a] < 0) begin
        m = DW'(-dlo_r[a]);
      end else if (dhi_r[a] < 0) begin
        m = DW'(-dhi_r[a]);
      end else begin
        m = '0;
      end
      neg2_nxt[a] = dlo_r[a] < 0;
      mag2_nxt[a] = m[RW-1:0];
      if (m > {2'b00, r1_r}) begin
        far2_nxt = 1'b1;
      end
      fsel2_nxt[a] = dhi_r[a] < dlo_r[a];
      fd2_nxt[a]   = fsel2_nxt[a] ? dhi_r[a] : dlo_r[a];
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sq3_nxt[a] = 62'(mag2_r[a]) * 62'(mag2_r[a]);
    end
    if (fd2_r[1] < fd2_r[0]) begin
      bxy3_nxt = fd2_r[1];
      bax3_nxt = 2'd1;
      bhi3_nxt = fsel2_r[1];
    end else begin
      bxy3_nxt = fd2_r[0];
      bax3_nxt = 2'd0;
      bhi3_nxt = fsel2_r[0];
    end
  end

  always_comb begin
    if (fdz3_r < bxy3_r) begin
      best4_nxt = fdz3_r;
      bax4_nxt  = 2'd2;
      bhi4_nxt  = fselz3_r;
    end else begin
      best4_nxt = bxy3_r;
      bax4_nxt  = bax3_r;
      bhi4_nxt  = bhi3_r;
    end
  end

  always_comb begin
    nohit   = far4_r || (dsq4_r > 64'(rr4_r));
    outside = !nohit && (dsq4_r > 64'(thr));
    pw      = $signed({4'b0000, r4_r}) - $signed({{2{best4_r[DW-1]}}, best4_r});
    meta5_nxt         = '0;
    meta5_nxt.outside = outside;
    meta5_nxt.neg     = neg4_r;
    meta5_nxt.r       = r4_r;
    for (int a = 0; a < 3; a++) begin
      meta5_nxt.mag[a] = mag4_r[a];
    end
    if (!nohit && !outside) begin
      meta5_nxt.res.center_inside = 1'b1;
      if (pw > 0) begin
        meta5_nxt.res.hit = 1'b1;
        meta5_nxt.res.penetration = (pw > $signed({4'b0000, PEN_MAX})) ? PEN_MAX
                                                                      : pw[RW-1:0];
        case (bax4_r)
          2'd0:    meta5_nxt.res.normal_x = bhi4_r ? ONE_Q14 : -ONE_Q14;
          2'd1:    meta5_nxt.res.normal_y = bhi4_r ? ONE_Q14 : -ONE_Q14;
          default: meta5_nxt.res.normal_z = bhi4_r ? ONE_Q14 : -ONE_Q14;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        dlo_r[a]  <= dlo_nxt[a];
        dhi_r[a]  <= dhi_nxt[a];
        mag2_r[a] <= mag2_nxt[a];
        fd2_r[a]  <= fd2_nxt[a];
        sq3_r[a]  <= sq3_nxt[a];
        mag3_r[a] <= mag2_r[a];
        mag4_r[a] <= mag3_r[a];
      end
      r1_r     <= in_data.radius;
      neg2_r   <= neg2_nxt;
      far2_r   <= far2_nxt;
      fsel2_r  <= fsel2_nxt;
      r2_r     <= r1_r;
      rr3_r    <= 62'(r2_r) * 62'(r2_r);
      neg3_r   <= neg2_r;
      far3_r   <= far2_r;
      bxy3_r   <= bxy3_nxt;
      bax3_r   <= bax3_nxt;
      bhi3_r   <= bhi3_nxt;
      fdz3_r   <= fd2_r[2];
      fselz3_r <= fsel2_r[2];
      r3_r     <= r2_r;
      dsq4_r   <= 64'(sq3_r[0]) + 64'(sq3_r[1]) + 64'(sq3_r[2]);
      rr4_r    <= rr3_r;
      neg4_r   <= neg3_r;
      far4_r   <= far3_r;
      best4_r  <= best4_nxt;
      bax4_r   <= bax4_nxt;
      bhi4_r   <= bhi4_nxt;
      r4_r     <= r3_r;
      dsq5_r   <= dsq4_r;
      meta5_r  <= meta5_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_dsq   = dsq5_r;
  assign out_meta  = meta5_r;

endmodule
`default_nettype wire

// File: hw/rtl/sbc_isqrt.sv
`default_nettype none
module sbc_isqrt (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [63:0]        in_rad,
  input  wire sbc_pkg::meta_t     in_meta,
  output logic                    out_valid,
  output logic [31:0]             out_root,
  output sbc_pkg::meta_t          out_meta
);
  import sbc_pkg::*;

  logic [SQ_STAGES-1:0] vld_r;
  sq_t                  st_r   [SQ_STAGES];
  meta_t                meta_r [SQ_STAGES];
  sq_t                  st_nxt [SQ_STAGES];
  sq_t                  src;

  // two result bits per stage
  always_comb begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        src.x   = in_rad;
        src.res = '0;
      end else begin
        src = st_r[k-1];
      end
      for (int j = 0; j < SQ_STEPS; j++) begin
        src = sq_step(src, 6'(62 - 2 * (SQ_STEPS * k + j)));
      end
      st_nxt[k] = src;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQ_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        st_r[k]   <= st_nxt[k];
        meta_r[k] <= (k == 0) ? in_meta : meta_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[SQ_STAGES-1];
  assign out_root  = st_r[SQ_STAGES-1].res[31:0];
  assign out_meta  = meta_r[SQ_STAGES-1];

endmodule
`default_nettype wire

// File: hw/rtl/sbc_div.sv
`default_nettype none
module sbc_div (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  en,
  input  wire logic                                  in_valid,
  input  wire logic [31:0]                           in_dist,
  input  wire sbc_pkg::meta_t                        in_meta,
  output logic                                       out_valid,
  output logic [2:0][sbc_pkg::DIV_BITS-1:0]          out_q,
  output sbc_pkg::meta_t                             out_meta
);
  import sbc_pkg::*;

  logic [DIV_BITS-1:0]          vld_r;
  logic [2:0][REM_W-1:0]        rem_r  [DIV_BITS];
  logic [2:0][DIV_BITS-1:0]     q_r    [DIV_BITS];
  logic [32:0]                  d_r    [DIV_BITS];
  meta_t                        meta_r [DIV_BITS];
  logic [2:0][REM_W-1:0]        rem_nxt [DIV_BITS];
  logic [2:0][DIV_BITS-1:0]     q_nxt   [DIV_BITS];
  logic [32:0]                  d_nxt   [DIV_BITS];
  logic [REM_W-1:0]             rem;
  logic [REM_W-1:0]             dsh;

  // one quotient bit per stage, most significant first
  always_comb begin
    for (int k = 0; k < DIV_BITS; k++) begin
      d_nxt[k] = (k == 0) ? {in_dist, 1'b0} : d_r[k-1];
      dsh      = REM_W'(d_nxt[k]) << (DIV_BITS - 1 - k);
      for (int a = 0; a < 3; a++) begin
        if (k == 0) begin
          rem         = REM_W'({in_meta.mag[a], {DIV_BITS{1'b0}}}) + REM_W'(in_dist);
          q_nxt[k][a] = '0;
        end else begin
          rem         = rem_r[k-1][a];
          q_nxt[k][a] = q_r[k-1][a];
        end
        if (rem >= dsh) begin
          rem = rem - dsh;
          q_nxt[k][a][DIV_BITS-1-k] = 1'b1;
        end
        rem_nxt[k][a] = rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_BITS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_BITS; k++) begin
        rem_r[k]  <= rem_nxt[k];
        q_r[k]    <= q_nxt[k];
        d_r[k]    <= d_nxt[k];
        meta_r[k] <= (k == 0) ? in_meta : meta_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[DIV_BITS-1];
  assign out_q     = q_r[DIV_BITS-1];
  assign out_meta  = meta_r[DIV_BITS-1];

endmodule
`default_nettype wire

// File: hw/rtl/sphere_box_contact_top.sv
// Sphere against axis-aligned box contact test, fully pipelined: one request is taken every
// cycle while the output does not stall (5 geometry stages, 16 square-root stages at
// two root bits each, 15 divider stages at one normal bit each, one output register). The
// whole pipeline advances together; in_ready drops only while a result sits unaccepted in
// the output register. inside_threshold_sq sits at byte address 0 and is read at the last
// geometry stage, so write it only while no request is in flight.
`default_nettype none
module sphere_box_contact_top (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire sbc_pkg::in_t    in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sbc_pkg::out_t        out_data,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import sbc_pkg::*;

  logic                       en;
  logic [31:0]                thr_r;
  logic                       fr_valid;
  logic [63:0]                fr_dsq;
  meta_t                      fr_meta;
  logic                       sq_valid;
  logic [31:0]                sq_root;
  meta_t                      sq_meta;
  logic [31:0]                root_nz;
  meta_t                      dv_meta_in;
  logic                       dv_valid;
  logic [2:0][DIV_BITS-1:0]   dv_q;
  meta_t                      dv_meta;
  logic                       out_valid_r;
  out_t                       out_data_r;
  out_t                       out_data_nxt;
  logic [DIV_BITS-1:0]        qs;
  logic [NW-1:0]              nrm [3];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THR) ? thr_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 32'd1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THR)) begin
      thr_r <= pwdata;
    end
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  sbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .thr       (thr_r),
    .out_valid (fr_valid),
    .out_dsq   (fr_dsq),
    .out_meta  (fr_meta)
  );

  sbc_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_rad    (fr_dsq),
    .in_meta   (fr_meta),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_meta  (sq_meta)
  );

  // outside depth is radius minus distance
  always_comb begin
    root_nz    = (sq_root == '0) ? 32'd1 : sq_root;
    dv_meta_in = sq_meta;
    if (sq_meta.outside) begin
      dv_meta_in.res.hit         = 1'b1;
      dv_meta_in.res.penetration = ({1'b0, sq_meta.r} >= root_nz)
                                   ? RW'({1'b0, sq_meta.r} - root_nz) : '0;
    end
  end

  sbc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_dist   (root_nz),
    .in_meta   (dv_meta_in),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_meta  (dv_meta)
  );

  always_comb begin
    qs = '0;
    for (int a = 0; a < 3; a++) begin
      qs     = (dv_q[a] > Q_MAX) ? Q_MAX : dv_q[a];
      nrm[a] = dv_meta.neg[a] ? NW'(-{1'b0, qs}) : NW'({1'b0, qs});
    end
    out_data_nxt = dv_meta.res;
    if (dv_meta.outside) begin
      out_data_nxt.normal_x = nrm[0];
      out_data_nxt.normal_y = nrm[1];
      out_data_nxt.normal_z = nrm[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == !(out_valid && !out_ready))
    else $error("in_ready does not follow output stall");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.normal_x == 0 && out_data.normal_y == 0 &&
      out_data.normal_z == 0 && out_data.penetration == 0)
    else $error("miss with nonzero normal or depth");
  a_face_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit && out_data.center_inside |->
      $onehot({out_data.normal_x != 0, out_data.normal_y != 0, out_data.normal_z != 0}))
    else $error("face contact normal not on one axis");
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.normal_x >= -16384 && out_data.normal_x <= 16384 &&
      out_data.normal_y >= -16384 && out_data.normal_y <= 16384 &&
      out_data.normal_z >= -16384 && out_data.normal_z <= 16384)
    else $error("normal component beyond unit");
`endif

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int N_RANDOM       = 1350;

  typedef enum int {GEO_OUTSIDE, GEO_INSIDE, GEO_FAR, GEO_EDGE, GEO_NOISE} geo_kind_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] thr_sq;
  out_t        contact_q[$];
  int          n_fail = 0;
  int          n_sent = 0;
  int          n_got = 0;
  int          n_hit_in = 0;
  int          n_hit_out = 0;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;

  always #4 clk = ~clk;

  sphere_box_contact_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] unit_comp(logic neg, logic [63:0] mag,
                                                  logic [63:0] den);
    logic [63:0] q;
    q = ((mag << 15) + den) / (2 * den);
    if (q > 16384) q = 16384;
    return neg ? -16'(q) : 16'(q);
  endfunction

  function automatic out_t contact_of(in_t p);
    out_t o;
    logic signed [63:0] c[3], lo[3], hi[3], off[3], cl, fbest, fd;
    logic [63:0] mag[3], r, dsq, dlen, pen;
    logic far;
    int fi;
    o = '0;
    far = 0;
    dsq = 0;
    r = 64'(p.radius);
    c[0] = 64'(p.center_x);  c[1] = 64'(p.center_y);  c[2] = 64'(p.center_z);
    lo[0] = 64'(p.box_min_x); lo[1] = 64'(p.box_min_y); lo[2] = 64'(p.box_min_z);
    hi[0] = 64'(p.box_max_x); hi[1] = 64'(p.box_max_y); hi[2] = 64'(p.box_max_z);
    for (int a = 0; a < 3; a++) begin
      cl = (c[a] < lo[a]) ? lo[a] : ((c[a] > hi[a]) ? hi[a] : c[a]);
      off[a] = c[a] - cl;
      mag[a] = (off[a] < 0) ? -off[a] : off[a];
      if (mag[a] > r) far = 1;
    end
    if (far) return o;
    for (int a = 0; a < 3; a++) dsq += mag[a] * mag[a];
    if (dsq > r * r) return o;
    if (dsq > 64'(thr_sq)) begin
      dlen = root_floor(dsq);
      if (dlen == 0) dlen = 1;
      o.hit = 1;
      o.normal_x = unit_comp(off[0] < 0, mag[0], dlen);
      o.normal_y = unit_comp(off[1] < 0, mag[1], dlen);
      o.normal_z = unit_comp(off[2] < 0, mag[2], dlen);
      o.penetration = (r >= dlen) ? 31'(r - dlen) : '0;
      return o;
    end
    o.center_inside = 1;
    fbest = c[0] - lo[0];
    fi = 0;
    for (int k = 1; k < 6; k++) begin
      fd = (k & 1) ? hi[k >> 1] - c[k >> 1] : c[k >> 1] - lo[k >> 1];
      if (fd < fbest) begin
        fbest = fd;
        fi = k;
      end
    end
    if (fbest < $signed(r)) begin
      pen = $signed(r) - fbest;
      if (pen > 64'h7fffffff) pen = 64'h7fffffff;
      o.hit = 1;
      o.penetration = 31'(pen);
      case (fi >> 1)
        0: o.normal_x = (fi & 1) ? ONE_Q14 : -ONE_Q14;
        1: o.normal_y = (fi & 1) ? ONE_Q14 : -ONE_Q14;
        default: o.normal_z = (fi & 1) ? ONE_Q14 : -ONE_Q14;
      endcase
    end
    return o;
  endfunction

  task automatic send_request(in_t p, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    contact_q.push_back(contact_of(p));
    n_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 3'(REG_THR) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    thr_sq = v;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_coord(int span);
    return $signed(32'($urandom_range(2 * span))) - span;
  endfunction

  function automatic in_t rnd_pair(geo_kind_e kind);
    in_t p;
    logic signed [31:0] lo, ext, c;
    int span;
    span = ($urandom_range(9) == 0) ? 32'h3fff_ffff : (1 << $urandom_range(22, 12));
    p = '0;
    p.radius = 31'($urandom_range(span));
    if ($urandom_range(15) == 0) p.radius = 31'($urandom);
    for (int a = 0; a < 3; a++) begin
      lo = rnd_coord(span);
      ext = 32'($urandom_range(span));
      case (kind)
        GEO_INSIDE:  c = lo + 32'($urandom_range(ext));
        GEO_OUTSIDE: c = ($urandom_range(1) ? lo - 32'($urandom_range(p.radius / 2))
                                            : lo + ext + 32'($urandom_range(p.radius / 2)));
        GEO_EDGE:    c = $urandom_range(1) ? lo : lo + ext;
        GEO_FAR:     c = rnd_coord(span);
        default:     c = $urandom;
      endcase
      if (kind == GEO_NOISE) begin
        lo = $urandom;
        ext = $urandom;
      end
      case (a)
        0: begin p.center_x = c; p.box_min_x = lo; p.box_max_x = lo + ext; end
        1: begin p.center_y = c; p.box_min_y = lo; p.box_max_y = lo + ext; end
        default: begin p.center_z = c; p.box_min_z = lo; p.box_max_z = lo + ext; end
      endcase
    end
    return p;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_got++;
      if (contact_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        n_fail++;
      end else begin
        out_t e;
        e = contact_q.pop_front();
        if (e.hit && e.center_inside) n_hit_in++;
        if (e.hit && !e.center_inside) n_hit_out++;
        if (out_data.hit !== e.hit || out_data.center_inside !== e.center_inside ||
            out_data.normal_x !== e.normal_x || out_data.normal_y !== e.normal_y ||
            out_data.normal_z !== e.normal_z || out_data.penetration !== e.penetration) begin
          $display("%0t: contact mismatch expected %p actual %p", $time, e, out_data);
          n_fail++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      w = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
      if (w == 0 || n_sent < 40) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", contact_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    in_t d_rows[$];
    out_t d_fixed[$];
    bit d_typed[$];
    in_t p;
    out_t z;
    int gap;
    logic [31:0] thr_list[4];
    geo_kind_e kind;
    thr_sq = 32'd1;
    thr_list = '{32'd0, 32'hffff_ffff, 32'd1 << 30, 32'd1};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    z = '0;
    // all zero: point sphere inside a point box
    p = '0;
    d_rows.push_back(p); d_typed.push_back(1); z.center_inside = 1; d_fixed.push_back(z);
    // far along one axis
    p = '0; p.center_x = 32'sh7fff_ffff; p.radius = 31'd1;
    d_rows.push_back(p); d_typed.push_back(1); d_fixed.push_back('0);
    p = '0; p.center_y = 32'sh8000_0000; p.radius = 31'h7fff_ffff;
    d_rows.push_back(p); d_typed.push_back(1); d_fixed.push_back('0);
    // inside, nearest face each of six
    for (int k = 0; k < 6; k++) begin
      p = '0;
      p.box_min_x = -32'sd1000; p.box_max_x = 32'sd1000;
      p.box_min_y = -32'sd1000; p.box_max_y = 32'sd1000;
      p.box_min_z = -32'sd1000; p.box_max_z = 32'sd1000;
      p.radius = 31'd500;
      case (k)
        0: p.center_x = -32'sd900;
        1: p.center_x = 32'sd900;
        2: p.center_y = -32'sd900;
        3: p.center_y = 32'sd900;
        4: p.center_z = -32'sd900;
        default: p.center_z = 32'sd900;
      endcase
      z = '0; z.hit = 1; z.center_inside = 1; z.penetration = 31'd400;
      case (k)
        0: z.normal_x = -ONE_Q14;
        1: z.normal_x = ONE_Q14;
        2: z.normal_y = -ONE_Q14;
        3: z.normal_y = ONE_Q14;
        4: z.normal_z = -ONE_Q14;
        default: z.normal_z = ONE_Q14;
      endcase
      d_rows.push_back(p); d_typed.push_back(1); d_fixed.push_back(z);
    end
    // inside but face beyond radius: no hit
    p = '0; p.box_min_x = -32'sd1000; p.box_max_x = 32'sd1000;
    p.box_min_y = -32'sd1000; p.box_max_y = 32'sd1000;
    p.box_min_z = -32'sd1000; p.box_max_z = 32'sd1000; p.radius = 31'd10;
    z = '0; z.center_inside = 1;
    d_rows.push_back(p); d_typed.push_back(1); d_fixed.push_back(z);
    // outside on an axis
    p = '0; p.center_x = 32'sd300; p.radius = 31'd1000;
    z = '0; z.hit = 1; z.normal_x = ONE_Q14; z.penetration = 31'd700;
    d_rows.push_back(p); d_typed.push_back(1); d_fixed.push_back(z);
    p = '0; p.center_z = -32'sd300; p.radius = 31'd300;
    z = '0; z.hit = 1; z.normal_z = -ONE_Q14;
    d_rows.push_back(p); d_typed.push_back(1); d_fixed.push_back(z);
    // diagonal outside, malformed box, extreme corners: predictor only
    p = '0; p.center_x = 32'sd3; p.center_y = 32'sd4; p.radius = 31'd7;
    d_rows.push_back(p); d_typed.push_back(0); d_fixed.push_back('0);
    p = '0; p.center_x = -32'sd1; p.center_y = 32'sd1; p.center_z = -32'sd1; p.radius = 31'd2;
    d_rows.push_back(p); d_typed.push_back(0); d_fixed.push_back('0);
    p = '0; p.box_min_x = 32'sd500; p.box_max_x = -32'sd500; p.radius = 31'd2000;
    d_rows.push_back(p); d_typed.push_back(0); d_fixed.push_back('0);
    p = '1; p.radius = 31'h7fff_ffff;
    d_rows.push_back(p); d_typed.push_back(0); d_fixed.push_back('0);
    p = '0; p.box_min_x = 32'sh8000_0000; p.box_max_x = 32'sh7fff_ffff;
    p.box_min_y = 32'sh8000_0000; p.box_max_y = 32'sh7fff_ffff;
    p.box_min_z = 32'sh8000_0000; p.box_max_z = 32'sh7fff_ffff; p.radius = 31'h7fff_ffff;
    d_rows.push_back(p); d_typed.push_back(0); d_fixed.push_back('0);
    p = '0; p.center_x = 32'sh7fff_ffff; p.box_min_x = 32'sh8000_0000;
    p.box_max_x = 32'sh8000_0000; p.radius = 31'h7fff_ffff;
    d_rows.push_back(p); d_typed.push_back(0); d_fixed.push_back('0);

    foreach (d_rows[i]) begin
      send_request(d_rows[i], 0);
      if (d_typed[i] && contact_of(d_rows[i]) !== d_fixed[i]) begin
        $display("%0t: directed row %0d expected %p predicted %p", $time, i,
                 d_fixed[i], contact_of(d_rows[i]));
        n_fail++;
      end
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(thr_list[ph]);
      if (ph == 2) hold_off = 1'b1;
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        case ($urandom_range(9))
          0, 1, 2: kind = GEO_INSIDE;
          3, 4, 5: kind = GEO_OUTSIDE;
          6: kind = GEO_EDGE;
          7: kind = GEO_FAR;
          default: kind = GEO_NOISE;
        endcase
        gap = ($urandom_range(3) == 0 || (i > 100 && i < 160)) ? 0 : $urandom_range(6);
        send_request(rnd_pair(kind), gap);
        if (i == N_RANDOM / 8) wait_drained();
      end
      wait_drained();
    end

    $display("%0d requests, %0d results, %0d outside hits, %0d inside hits",
             n_sent, n_got, n_hit_out, n_hit_in);
    $display("thresholds 0, 1, 2^30 and all ones, with stalls and a long hold-off");
    if (n_fail == 0 && contact_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
hw/rtl/sbc_pkg.sv
hw/rtl/sbc_front.sv
hw/rtl/sbc_isqrt.sv
hw/rtl/sbc_div.sv
hw/rtl/sphere_box_contact_top.sv
tb/tb_top.sv
